// ----- rtl/sdrrip_pkg.sv -----
// Shared types and constants of the DRRIP/SHiP replacement engine.
package sdrrip_pkg;

  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [9:0] DUEL_MID  = 10'd512;
  localparam logic [9:0] DUEL_MAX  = 10'd1023;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] phys_addr;
    logic [5:0]  pc_signature;
    logic        is_hit;
    logic [4:0]  bimodal_draw;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       stream_seen;
    logic [1:0] inserted_rrpv;
  } rsp_t;

endpackage

// ----- rtl/sdrrip_ram.sv -----
// Generic single-port RAM with registered read.
module sdrrip_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/sdrrip_front.sv -----
// Front end: accept beats, fold indices, queue them for the back end.
module sdrrip_front #(
  parameter int NumSets = 2048,
  parameter int NumWays = 16,
  parameter int SigWidth = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sdrrip_pkg::req_t  req_i,
  output logic              busy_o,
  output logic              q_valid_o,
  output sdrrip_pkg::req_t  q_req_o,
  input  logic              q_pop_i
);
  localparam int SetW = $clog2(NumSets);
  localparam int WayW = $clog2(NumWays);

  // two-entry queue
  sdrrip_pkg::req_t slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;
  sdrrip_pkg::req_t norm;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  // wrap set, way and signature into range
  always_comb begin
    norm = req_i;
    norm.set_index = 11'(SetW'(req_i.set_index));
    norm.way_index = 4'(WayW'(req_i.way_index));
    norm.pc_signature = 6'(SigWidth'(req_i.pc_signature));
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= norm;
  end
endmodule

// ----- rtl/sdrrip_back.sv -----
// Back end: clearing pass, read-modify-write of set state, result strobe.
module sdrrip_back #(
  parameter int NumSets = 2048,
  parameter int NumWays = 16,
  parameter int LeaderCount = 64,
  parameter int SigWidth = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sdrrip_pkg::req_t  q_req_i,
  output logic              q_pop_o,
  output logic              init_o,
  output logic              done_o,
  output sdrrip_pkg::rsp_t  rsp_o
);
  localparam int SetW = $clog2(NumSets);
  localparam int WayW = $clog2(NumWays);
  localparam int SigN = 1 << SigWidth;
  localparam int Spacing = NumSets / LeaderCount;
  localparam int ClrN = (NumSets > SigN) ? NumSets : SigN;
  localparam int ClrW = $clog2(ClrN);
  localparam int RowW = 2 * NumWays + SigWidth * NumWays + 2 * NumWays;
  localparam int StrW = 64 + 64 + 2 + 1;

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_REUSE = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [ClrW-1:0] clr_q;
  sdrrip_pkg::req_t r_q;
  logic [9:0]  duel_q, duel_d;
  logic [SigWidth-1:0] oldsig_q;

  logic [SetW-1:0] s;
  logic [WayW-1:0] w;
  logic [SigWidth-1:0] sig;

  // per-set rows: rrpv, signatures, dead counts
  logic row_we, str_we;
  logic [SetW-1:0] ram_addr;
  logic [RowW-1:0] row_rd, row_wd;
  logic [StrW-1:0] str_rd, str_wd;

  // reuse counters indexed by signature
  logic reuse_we;
  logic [SigWidth-1:0] reuse_addr;
  logic [1:0] reuse_rd, reuse_wd;

  assign s   = SetW'(r_q.set_index);
  assign w   = WayW'(r_q.way_index);
  assign sig = SigWidth'(r_q.pc_signature);

  sdrrip_ram #(.Width(RowW), .Depth(NumSets)) u_row (
    .clk_i, .we_i(row_we), .addr_i(ram_addr), .wdata_i(row_wd), .rdata_o(row_rd)
  );
  sdrrip_ram #(.Width(StrW), .Depth(NumSets)) u_str (
    .clk_i, .we_i(str_we), .addr_i(ram_addr), .wdata_i(str_wd), .rdata_o(str_rd)
  );
  sdrrip_ram #(.Width(2), .Depth(SigN)) u_reuse (
    .clk_i, .we_i(reuse_we), .addr_i(reuse_addr), .wdata_i(reuse_wd), .rdata_o(reuse_rd)
  );

  logic [1:0] rr [NumWays];
  logic [SigWidth-1:0] sg [NumWays];
  logic [1:0] dc [NumWays];
  logic [1:0] rr_n [NumWays];
  logic [SigWidth-1:0] sg_n [NumWays];
  logic [1:0] dc_n [NumWays];
  logic [63:0] la, ld, delta, la_n, ld_n;
  logic [1:0]  cf, cf_n;
  logic        fl, fl_n;
  logic [1:0]  kind, top, add, ins, reuse_new, rsig;
  logic [WayW-1:0] vict;
  logic        found, pick_srrip;
  logic [SigWidth-1:0] old_sig;

  always_comb begin
    for (int k = 0; k < NumWays; k++) begin
      rr[k] = row_rd[2*k +: 2];
      sg[k] = row_rd[2*NumWays + SigWidth*k +: SigWidth];
      dc[k] = row_rd[2*NumWays + SigWidth*NumWays + 2*k +: 2];
    end
    {la, ld, cf, fl} = str_rd;
  end

  // leader classification: match the set against each leader position
  always_comb begin
    kind = 2'd0;
    if (Spacing == 0) begin
      kind = (s == '0) ? 2'd1 : 2'd0;
    end else begin
      for (int i = 0; i < LeaderCount; i++) begin
        if (32'(s) == i * Spacing) kind = (i < LeaderCount / 2) ? 2'd1 : 2'd2;
      end
    end
  end

  // execute one item against the read row
  always_comb begin
    rr_n = rr; sg_n = sg; dc_n = dc;
    la_n = la; ld_n = ld; cf_n = cf; fl_n = fl;
    duel_d = duel_q;
    ins = 2'd0; vict = '0; found = 1'b0; top = 2'd0;
    old_sig = sg[w];
    rsig = reuse_rd;
    reuse_new = rsig;
    delta = r_q.phys_addr - la;
    pick_srrip = (kind == 2'd1) || (kind == 2'd0 && duel_q >= sdrrip_pkg::DUEL_MID);
    for (int k = 0; k < NumWays; k++) if (rr[k] > top) top = rr[k];
    add = sdrrip_pkg::RRPV_MAX - top;
    unique case (r_q.opcode)
      sdrrip_pkg::OP_VICTIM: begin
        for (int k = 0; k < NumWays; k++) begin
          rr_n[k] = rr[k] + add;
          if (!found && rr_n[k] == sdrrip_pkg::RRPV_MAX) begin
            found = 1'b1; vict = WayW'(k);
          end
        end
      end
      sdrrip_pkg::OP_UPDATE: begin
        if (la != '0) begin
          if (delta == ld && delta != '0) cf_n = (cf == 2'd3) ? cf : cf + 2'd1;
          else cf_n = (cf == 2'd0) ? cf : cf - 2'd1;
          fl_n = cf_n[1];
        end
        ld_n = delta; la_n = r_q.phys_addr;
        sg_n[w] = sig;
        if (r_q.is_hit) begin
          rr_n[w] = 2'd0;
          dc_n[w] = (dc[w] == 2'd0) ? 2'd0 : dc[w] - 2'd1;
          reuse_new = (rsig == 2'd3) ? rsig : rsig + 2'd1;
          if (kind == 2'd1 && duel_q != sdrrip_pkg::DUEL_MAX) duel_d = duel_q + 10'd1;
          if (kind == 2'd2 && duel_q != '0) duel_d = duel_q - 10'd1;
        end else begin
          if (fl_n || dc[w] >= 2'd2) ins = sdrrip_pkg::RRPV_MAX;
          else if (rsig >= 2'd2) ins = 2'd0;
          else ins = (pick_srrip || r_q.bimodal_draw == '0) ? 2'd2 : sdrrip_pkg::RRPV_MAX;
          rr_n[w] = ins;
          dc_n[w] = 2'd0;
        end
      end
      sdrrip_pkg::OP_EVICT: begin
        dc_n[w] = (dc[w] == 2'd3) ? dc[w] : dc[w] + 2'd1;
      end
      default: ;
    endcase
    for (int k = 0; k < NumWays; k++) begin
      row_wd[2*k +: 2] = rr_n[k];
      row_wd[2*NumWays + SigWidth*k +: SigWidth] = sg_n[k];
      row_wd[2*NumWays + SigWidth*NumWays + 2*k +: 2] = dc_n[k];
    end
    str_wd = {la_n, ld_n, cf_n, fl_n};
    if (st_q == ST_INIT) begin
      for (int k = 0; k < NumWays; k++) begin
        row_wd[2*k +: 2] = sdrrip_pkg::RRPV_MAX;
        row_wd[2*NumWays + SigWidth*k +: SigWidth] = '0;
        row_wd[2*NumWays + SigWidth*NumWays + 2*k +: 2] = '0;
      end
      str_wd = '0;
    end
  end

  assign init_o   = (st_q == ST_INIT);
  assign q_pop_o  = (st_q == ST_IDLE) && q_valid_i;
  assign ram_addr = (st_q == ST_INIT) ? SetW'(clr_q) :
                    (q_pop_o ? SetW'(q_req_i.set_index) : s);
  assign row_we   = (st_q == ST_INIT) || (st_q == ST_EXEC);
  assign str_we   = (st_q == ST_INIT) ||
                    (st_q == ST_EXEC && r_q.opcode == sdrrip_pkg::OP_UPDATE);
  assign done_o   = (st_q == ST_EXEC);
  assign rsp_o.victim_way    = 4'(vict);
  assign rsp_o.stream_seen   = fl_n;
  assign rsp_o.inserted_rrpv = ins;

  // reuse table: read at pop for updates, at the old signature for evictions
  assign reuse_addr = (st_q == ST_INIT)  ? SigWidth'(clr_q) :
                      (st_q == ST_REUSE) ? oldsig_q :
                      q_pop_o ? SigWidth'(q_req_i.pc_signature) :
                      (st_q == ST_EXEC && r_q.opcode == sdrrip_pkg::OP_EVICT) ? old_sig : sig;
  assign reuse_we   = (st_q == ST_INIT) || (st_q == ST_REUSE) ||
                      (st_q == ST_EXEC && r_q.opcode == sdrrip_pkg::OP_UPDATE);
  assign reuse_wd   = (st_q == ST_INIT) ? 2'd0 :
                      (st_q == ST_REUSE) ? ((reuse_rd == 2'd0) ? 2'd0 : reuse_rd - 2'd1) :
                      reuse_new;

  // sequencer: clear, idle, execute, then reuse decrement for evictions
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_INIT:  if (clr_q == ClrW'(ClrN - 1)) st_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i) st_d = ST_EXEC;
      ST_EXEC:  st_d = (r_q.opcode == sdrrip_pkg::OP_EVICT) ? ST_REUSE : ST_IDLE;
      ST_REUSE: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_INIT;
      clr_q  <= '0;
      duel_q <= sdrrip_pkg::DUEL_MID;
    end else begin
      st_q <= st_d;
      if (st_q == ST_INIT) clr_q <= clr_q + ClrW'(1);
      if (st_q == ST_EXEC) duel_q <= duel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) r_q <= q_req_i;
    if (st_q == ST_EXEC) oldsig_q <= old_sig;
  end
endmodule

// ----- rtl/ship_drrip_stream_bypass_replacement_top.sv -----
// Top level of the DRRIP/SHiP replacement engine with stream bypass.
// channel  | signals                      | handshake
// request  | start_i, req_i, busy_o       | beat when start_i && !busy_o
// result   | done_o, rsp_o                | one-cycle strobe, no backpressure
// In the back end an item passes a RAM read, then an execute-and-write step.
// An eviction adds a further state, ST_REUSE, to decrement the reuse counter of the old signature.
// A two-entry queue lets the front take beats while the back end works.
// After reset a clearing pass over max(NUM_SETS, 2**SIG_WIDTH) entries holds busy_o high.
// The receiver cannot stall; results appear in beat order.
module ship_drrip_stream_bypass_replacement_top #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int LEADER_COUNT = 64,
  parameter int SIG_WIDTH = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sdrrip_pkg::req_t req_i,
  output logic             busy_o,
  output logic             done_o,
  output sdrrip_pkg::rsp_t rsp_o
);
  logic q_valid, q_pop, init, fbusy;
  sdrrip_pkg::req_t q_req;

  sdrrip_front #(.NumSets(NUM_SETS), .NumWays(NUM_WAYS), .SigWidth(SIG_WIDTH)) u_front (
    .clk_i, .rst_ni, .start_i(start_i && !init), .req_i, .busy_o(fbusy),
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  sdrrip_back #(.NumSets(NUM_SETS), .NumWays(NUM_WAYS), .LeaderCount(LEADER_COUNT),
                .SigWidth(SIG_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .init_o(init), .done_o, .rsp_o
  );

  assign busy_o = fbusy || init;

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_done_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> done_o) else $error("missing result after pop");
  a_no_done_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init |-> !done_o) else $error("result during clearing pass");
`endif
endmodule
